@@ hdl/ookmod_pkg.sv @@
package ookmod_pkg;

   // field and register widths fixed by the interface
   localparam int BYTE_BITS       = 8;
   localparam int PHASE_STEP_BITS = 24;
   localparam int SPB_BITS        = 16;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int RSP_TDATA_BITS  = 8;
   localparam int RSP_TUSER_BITS  = 3;
   localparam int BIT_COUNT_BITS  = 4;

   localparam logic [PHASE_STEP_BITS-1:0] PHASE_STEP_RESET = 24'd524288;
   localparam logic [SPB_BITS-1:0]        SPB_RESET        = 16'd16;
   localparam logic [BIT_COUNT_BITS-1:0]  BITS_PER_BYTE    = 4'd8;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // register index, taken from address bit 2
   typedef enum logic {
      CSR_IDX_PHASE_STEP = 1'b0,
      CSR_IDX_SPB        = 1'b1
   } csr_idx_type;

   // sine table generation, Q2.30 fixed point
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] HALF_Q30   = 64'd536870912;
   localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = a * b + HALF_Q30;
      return p >> 30;
   endfunction

   // round(128 * sin(2*pi*j / 2^addr_bits)) for the first quadrant
   function automatic logic [7:0] sine_mag(input logic [31:0] j, input int addr_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] r;
      x = ((64'(j) * TWO_PI_Q30) + (64'd1 << (addr_bits - 1))) >> addr_bits;
      x2 = qmul(x, x);
      term = x;
      acc = x;
      for (int n = 0; n < 8; n++) begin
         term = qmul(term, x2) / TAYLOR_DIV[n];
         if (n % 2 == 0) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      r = ((acc << 7) + HALF_Q30) >> 30;
      return (r > 64'd128) ? 8'd128 : r[7:0];
   endfunction

endpackage

@@ hdl/ookmod_ram.sv @@
module ookmod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ook_sine_carrier_modulator.sv @@
// channel | ports      | payload
// --------+------------+------------------------------------------------------------
// input   | req_t*     | tdata data_byte, tuser cmd (0 load, 1 tick), tlast last_byte
// result  | rsp_t*     | tdata sample, tuser {need_byte, bit_value, active},
//         |            | tlast end_of_message
// csr     | csr_p*     | 0x0 phase_step, 0x4 samples_per_bit
//
// one transfer accepted per cycle while req_tready is high; a tick's result passes
// through the middle stage, for the sine memory read, and then the output register.
// after reset the sine memory is loaded from the constant table, one entry a cycle,
// all 2**SINE_ADDR_BITS entries, with req_tready low; csr writes are taken throughout.
// a stalled rsp side holds the middle stage and the memory read data, and
// req_tready drops outside the table load only when both stages are full.
module ook_sine_carrier_modulator
   import ookmod_pkg::*;
#(
   parameter int PHASE_BITS        = 24,
   parameter int SINE_ADDR_BITS    = 8,
   parameter int SAMPLE_COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_BITS-1:0]      req_tdata,  // [7:0] data_byte
   input  logic                      req_tuser,  // [0] cmd
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // [7:0] sample
   output logic [RSP_TUSER_BITS-1:0] rsp_tuser,  // [0] active, [1] bit_value, [2] need_byte
   output logic                      rsp_tlast,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   localparam int ROM_DEPTH = 1 << SINE_ADDR_BITS;
   localparam int CMP_BITS  = ((SAMPLE_COUNT_BITS > SPB_BITS) ? SAMPLE_COUNT_BITS : SPB_BITS) + 1;

   typedef logic [7:0] sine_table_type [ROM_DEPTH];

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [31:0]    h;
      logic [31:0]    j;
      logic [8:0]     v;
      logic [7:0]     mag;
      logic           neg;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         neg = (k >= ROM_DEPTH / 2);
         h = neg ? 32'(k - ROM_DEPTH / 2) : 32'(k);
         j = (h <= 32'(ROM_DEPTH / 4)) ? h : 32'(ROM_DEPTH / 2) - h;
         mag = sine_mag(j, SINE_ADDR_BITS);
         v = neg ? (9'd128 - 9'(mag)) : (9'd128 + 9'(mag));
         tbl[k] = (v > 9'd255) ? 8'd255 : v[7:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // csr registers
   logic [PHASE_STEP_BITS-1:0] phase_step_ff;
   logic [SPB_BITS-1:0]        spb_ff;
   logic                       csr_write;

   // table load after reset
   logic                      filling_ff;
   logic [SINE_ADDR_BITS-1:0] fill_addr_ff;

   // modulator state
   logic [BYTE_BITS-1:0]         shift_byte_ff, shift_byte_in;
   logic [BIT_COUNT_BITS-1:0]    bits_left_ff, bits_left_in;
   logic [SAMPLE_COUNT_BITS-1:0] sample_cnt_ff, sample_cnt_in;
   logic [PHASE_BITS-1:0]        phase_ff, phase_in;
   logic [BYTE_BITS-1:0]         holding_byte_ff, holding_byte_in;
   logic                         holding_full_ff, holding_full_in;
   logic                         holding_last_ff, holding_last_in;
   logic                         current_last_ff, current_last_in;

   // middle stage, waiting for the memory read
   logic s1_valid_ff, s1_valid_in;
   logic s1_active_ff, s1_active_in;
   logic s1_bit_ff, s1_bit_in;
   logic s1_eom_ff, s1_eom_in;
   logic s1_need_ff, s1_need_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_TDATA_BITS-1:0] out_sample_ff;
   logic [RSP_TUSER_BITS-1:0] out_user_ff;
   logic                      out_eom_ff;

   logic                         req_fire, tick, load, s1_move;
   logic                         load_now, bit_end;
   logic [BYTE_BITS-1:0]         eff_shift;
   logic [BIT_COUNT_BITS-1:0]    eff_bits;
   logic [SAMPLE_COUNT_BITS-1:0] eff_cnt;
   logic                         eff_last;
   logic [SPB_BITS-1:0]          spb_eff;
   logic [SINE_ADDR_BITS-1:0]    rom_addr;
   logic [7:0]                   rom_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         spb_ff        <= SPB_RESET;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_paddr[2]))
            CSR_IDX_PHASE_STEP: phase_step_ff <= csr_pwdata[PHASE_STEP_BITS-1:0];
            CSR_IDX_SPB:        spb_ff <= csr_pwdata[SPB_BITS-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx_type'(csr_paddr[2]))
         CSR_IDX_PHASE_STEP: csr_prdata = CSR_DATA_BITS'(phase_step_ff);
         CSR_IDX_SPB:        csr_prdata = CSR_DATA_BITS'(spb_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filling_ff   <= 1'b1;
         fill_addr_ff <= '0;
      end else if (filling_ff) begin
         fill_addr_ff <= fill_addr_ff + 1'b1;
         if (fill_addr_ff == '1) begin
            filling_ff <= 1'b0;
         end
      end
   end

   generate
      if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_top
         assign rom_addr = phase_ff[PHASE_BITS-1 -: SINE_ADDR_BITS];
      end else begin : g_addr_shift
         assign rom_addr = {phase_ff, {(SINE_ADDR_BITS - PHASE_BITS){1'b0}}};
      end
   endgenerate

   ookmod_ram #(
      .WIDTH (8),
      .DEPTH (ROM_DEPTH)
   ) u_sine_ram (
      .clock   (clock),
      .wr_en   (filling_ff),
      .wr_addr (fill_addr_ff),
      .wr_data (SINE_TABLE[fill_addr_ff]),
      .rd_en   (tick),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !filling_ff && (!s1_valid_ff || s1_move);
   assign req_fire   = req_tvalid && req_tready;
   assign tick       = req_fire && (req_tuser == CMD_TICK);
   assign load       = req_fire && (req_tuser == CMD_LOAD);

   always_comb begin
      load_now  = (bits_left_ff == '0) && holding_full_ff;
      eff_bits  = load_now ? BITS_PER_BYTE : bits_left_ff;
      eff_shift = load_now ? holding_byte_ff : shift_byte_ff;
      eff_last  = load_now ? holding_last_ff : current_last_ff;
      eff_cnt   = load_now ? '0 : sample_cnt_ff;
      spb_eff   = (spb_ff == '0) ? SPB_BITS'(1) : spb_ff;
      bit_end   = ((CMP_BITS'(eff_cnt) + CMP_BITS'(1)) >= CMP_BITS'(spb_eff))
                  || (eff_cnt == '1);

      shift_byte_in   = shift_byte_ff;
      bits_left_in    = bits_left_ff;
      sample_cnt_in   = sample_cnt_ff;
      phase_in        = phase_ff;
      holding_byte_in = holding_byte_ff;
      holding_full_in = holding_full_ff;
      holding_last_in = holding_last_ff;
      current_last_in = current_last_ff;
      s1_active_in    = 1'b0;
      s1_bit_in       = 1'b0;
      s1_eom_in       = 1'b0;

      if (load && !holding_full_ff) begin
         holding_byte_in = req_tdata;
         holding_last_in = req_tlast;
         holding_full_in = 1'b1;
      end

      if (tick) begin
         shift_byte_in   = eff_shift;
         bits_left_in    = eff_bits;
         sample_cnt_in   = eff_cnt;
         current_last_in = eff_last;
         if (load_now) begin
            holding_full_in = 1'b0;
         end
         if (eff_bits != '0) begin
            s1_active_in = 1'b1;
            s1_bit_in    = eff_shift[BYTE_BITS-1];
            phase_in     = phase_ff + PHASE_BITS'(phase_step_ff);
            if (bit_end) begin
               sample_cnt_in = '0;
               shift_byte_in = {eff_shift[BYTE_BITS-2:0], 1'b0};
               bits_left_in  = eff_bits - 1'b1;
               if ((bits_left_in == '0) && eff_last) begin
                  s1_eom_in = 1'b1;
                  phase_in  = '0;
               end
            end else begin
               sample_cnt_in = eff_cnt + 1'b1;
            end
         end
      end

      s1_need_in  = !holding_full_in;
      s1_valid_in = tick ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_byte_ff   <= '0;
         bits_left_ff    <= '0;
         sample_cnt_ff   <= '0;
         phase_ff        <= '0;
         holding_full_ff <= 1'b0;
         holding_last_ff <= 1'b0;
         current_last_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         shift_byte_ff   <= shift_byte_in;
         bits_left_ff    <= bits_left_in;
         sample_cnt_ff   <= sample_cnt_in;
         phase_ff        <= phase_in;
         holding_full_ff <= holding_full_in;
         holding_last_ff <= holding_last_in;
         current_last_ff <= current_last_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      holding_byte_ff <= holding_byte_in;
      if (tick) begin
         s1_active_ff <= s1_active_in;
         s1_bit_ff    <= s1_bit_in;
         s1_eom_ff    <= s1_eom_in;
         s1_need_ff   <= s1_need_in;
      end
      // keyed carrier: zero for a zero bit or an idle tick
      if (s1_move) begin
         out_sample_ff <= s1_bit_ff ? rom_data : '0;
         out_user_ff   <= {s1_need_ff, s1_bit_ff, s1_active_ff};
         out_eom_ff    <= s1_eom_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_eom_ff;

   a_no_item_while_filling: assert property (@(posedge clock) disable iff (reset)
      filling_ff |-> !s1_valid_ff && !req_tready)
      else $error("item in flight during sine table load");

   a_bits_left_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= BITS_PER_BYTE)
      else $error("bit counter out of range");

   a_tick_reaches_s1: assert property (@(posedge clock) disable iff (reset)
      tick |=> s1_valid_ff)
      else $error("accepted tick lost before the read stage");

   a_eom_only_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("end of message on an idle sample");

   a_sample_keyed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata != '0) |-> rsp_tuser[1])
      else $error("carrier present on a zero bit");

endmodule
